/* rtl/ttim_pkg.sv */
`default_nettype none

package ttim_pkg;

  // Geometry
  localparam int MaxDims     = 6;
  localparam int IdxW        = 32;
  localparam int DimW        = 16;
  localparam int AxisW       = 3;
  localparam int RankW       = 3;
  localparam int CoordW      = 16;
  localparam int StrideW     = IdxW + 1;
  localparam int StepBits    = 2;
  localparam int StepsPerDim = CoordW / StepBits;
  localparam int DivStages   = MaxDims * StepsPerDim;
  localparam int DimIdxW     = $clog2(MaxDims);
  localparam int StepIdxW    = $clog2(StepsPerDim);
  localparam int PosW        = $clog2(CoordW);
  localparam int ShW         = StrideW + CoordW;

  // Configuration port
  localparam int CfgAddrW = 4;
  localparam int CfgDataW = MaxDims * AxisW;

  localparam logic [CfgAddrW-1:0] CfgRank = CfgAddrW'(0);
  localparam logic [CfgAddrW-1:0] CfgAxis = CfgAddrW'(1);
  localparam logic [CfgAddrW-1:0] CfgDim0 = CfgAddrW'(2);

  localparam logic [RankW-1:0]          RankReset = RankW'(1);
  localparam logic [MaxDims*AxisW-1:0]  AxisReset = (MaxDims*AxisW)'(181896);
  localparam logic [StrideW-1:0]        IdxCap    = {1'b1, {IdxW{1'b0}}};

  typedef enum logic [2:0] {
    PhIdle,
    PhIn,
    PhOdim,
    PhOut,
    PhSel
  } phase_e;

  // Derived strides handed from the config block to the datapath
  typedef struct packed {
    logic [MaxDims-1:0][StrideW-1:0] dst_stride;
    logic [MaxDims-1:0][IdxW-1:0]    sel_stride;
    logic [StrideW-1:0]              count;
    logic                            busy;
  } derived_t;

  // Payload of one divider pipeline stage
  typedef struct packed {
    logic [IdxW-1:0]                rem;
    logic [MaxDims-1:0][CoordW-1:0] coord;
    logic                           oor;
  } div_t;

  // Clamp the rank register into 1..MaxDims
  function automatic logic [RankW-1:0] eff_rank(input logic [RankW-1:0] r);
    logic [RankW-1:0] res;
    res = r;
    if (r == '0) res = RankW'(1);
    if (r > RankW'(MaxDims)) res = RankW'(MaxDims);
    return res;
  endfunction

endpackage

`default_nettype wire

/* rtl/ttim_cfg.sv */
`default_nettype none

module ttim_cfg (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_valid_i,
  output      logic                              cfg_ready_o,
  input  wire logic [ttim_pkg::CfgAddrW-1:0]     cfg_addr_i,
  input  wire logic [ttim_pkg::CfgDataW-1:0]     cfg_data_i,
  output      ttim_pkg::derived_t                derived_o
);
  import ttim_pkg::*;

  localparam logic [DimIdxW-1:0] KLast = DimIdxW'(MaxDims - 1);

  logic [RankW-1:0]                rank_q;
  logic [MaxDims*AxisW-1:0]        axis_q;
  logic [MaxDims-1:0][DimW-1:0]    dim_q;
  phase_e                          phase_q, phase_d;
  logic [DimIdxW-1:0]              k_q, k_d;
  logic [IdxW-1:0]                 pin_q;
  logic [StrideW-1:0]              pout_q;
  logic [MaxDims-1:0][IdxW-1:0]    in_stride_q;
  logic [MaxDims-1:0][DimW-1:0]    odim_q;
  logic [MaxDims-1:0][StrideW-1:0] dst_stride_q;
  logic [MaxDims-1:0][IdxW-1:0]    sel_q;
  logic [StrideW-1:0]              count_q;

  logic                            wr;
  logic [RankW-1:0]                rank;
  logic [AxisW-1:0]                axis_k;
  logic                            k_in;
  logic                            axis_in;
  logic [DimIdxW-1:0]              dim_idx;
  logic [IdxW+DimW-1:0]            pin_prod;
  logic [StrideW+DimW-1:0]         pout_prod;
  logic [StrideW-1:0]              pout_sat;

  assign cfg_ready_o = 1'b1;
  assign wr          = cfg_valid_i && cfg_ready_o;
  assign rank        = eff_rank(rank_q);
  assign axis_k      = axis_q[k_q*AxisW +: AxisW];
  assign k_in        = RankW'(k_q) < rank;
  assign axis_in     = k_in && (RankW'(axis_k) < rank);
  assign dim_idx     = DimIdxW'(cfg_addr_i - CfgDim0);
  assign pin_prod    = pin_q * dim_q[k_q];
  assign pout_prod   = pout_q * odim_q[k_q];
  assign pout_sat    = (pout_prod > (StrideW+DimW)'(IdxCap)) ? IdxCap : StrideW'(pout_prod);

  // Hold the programmed registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q <= RankReset;
      axis_q <= AxisReset;
      dim_q  <= '{default: DimW'(1)};
    end else if (wr) begin
      unique case (cfg_addr_i)
        CfgRank: rank_q <= cfg_data_i[RankW-1:0];
        CfgAxis: axis_q <= cfg_data_i[MaxDims*AxisW-1:0];
        default: begin
          if (cfg_addr_i >= CfgDim0 && cfg_addr_i < CfgDim0 + CfgAddrW'(MaxDims)) begin
            dim_q[dim_idx] <= cfg_data_i[DimW-1:0];
          end
        end
      endcase
    end
  end

  // Next phase of the stride sweep
  always_comb begin
    phase_d = phase_q;
    k_d     = k_q;
    unique case (phase_q)
      PhIdle: ;
      PhIn: begin
        if (k_q == '0) begin
          phase_d = PhOdim;
        end else begin
          k_d = k_q - DimIdxW'(1);
        end
      end
      PhOdim: begin
        if (k_q == KLast) begin
          phase_d = PhOut;
        end else begin
          k_d = k_q + DimIdxW'(1);
        end
      end
      PhOut: begin
        if (k_q == '0) begin
          phase_d = PhSel;
        end else begin
          k_d = k_q - DimIdxW'(1);
        end
      end
      PhSel: begin
        if (k_q == KLast) begin
          phase_d = PhIdle;
        end else begin
          k_d = k_q + DimIdxW'(1);
        end
      end
      default: phase_d = PhIdle;
    endcase
    if (wr) begin
      phase_d = PhIn;
      k_d     = KLast;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      k_q     <= '0;
    end else begin
      phase_q <= phase_d;
      k_q     <= k_d;
    end
  end

  // Sweep the strides, one dimension per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pin_q        <= IdxW'(1);
      pout_q       <= StrideW'(1);
      in_stride_q  <= (MaxDims*IdxW)'(1);
      odim_q       <= '{default: DimW'(1)};
      dst_stride_q <= (MaxDims*StrideW)'(1);
      sel_q        <= (MaxDims*IdxW)'(1);
      count_q      <= StrideW'(1);
    end else if (wr) begin
      pin_q  <= IdxW'(1);
      pout_q <= StrideW'(1);
    end else begin
      case (phase_q)
        PhIn: begin
          if (k_in) begin
            in_stride_q[k_q] <= pin_q;
            pin_q            <= pin_prod[IdxW-1:0];
          end else begin
            in_stride_q[k_q] <= '0;
          end
        end
        PhOdim: odim_q[k_q] <= axis_in ? dim_q[axis_k[DimIdxW-1:0]] : DimW'(1);
        PhOut: begin
          if (k_in) begin
            dst_stride_q[k_q] <= pout_q;
            pout_q            <= pout_sat;
          end else begin
            dst_stride_q[k_q] <= '0;
          end
        end
        PhSel: begin
          if (k_q == '0) count_q <= pout_q;
          sel_q[k_q] <= axis_in ? in_stride_q[axis_k[DimIdxW-1:0]] : '0;
        end
        default: ;
      endcase
    end
  end

  assign derived_o.dst_stride = dst_stride_q;
  assign derived_o.sel_stride = sel_q;
  assign derived_o.count      = count_q;
  assign derived_o.busy       = (phase_q != PhIdle);

endmodule

`default_nettype wire

/* rtl/ttim_div_stage.sv */
`default_nettype none

module ttim_div_stage (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            en_i,
  input  wire logic                            vld_i,
  input  wire ttim_pkg::div_t                  d_i,
  input  wire logic [ttim_pkg::StrideW-1:0]    stride_i,
  input  wire logic [ttim_pkg::DimIdxW-1:0]    dim_i,
  input  wire logic [ttim_pkg::StepIdxW-1:0]   step_i,
  output      logic                            vld_o,
  output      ttim_pkg::div_t                  d_o
);
  import ttim_pkg::*;

  div_t            d_d, d_q;
  logic            vld_q;
  logic [PosW-1:0] pos;
  logic [ShW-1:0]  shifted;

  // Two restoring quotient bits per stage
  always_comb begin
    d_d     = d_i;
    pos     = '0;
    shifted = '0;
    for (int j = 0; j < StepBits; j++) begin
      pos     = PosW'(CoordW - 1 - j) - PosW'(int'(step_i) * StepBits);
      shifted = ShW'(stride_i) << pos;
      if (stride_i != '0 && ShW'(d_d.rem) >= shifted) begin
        d_d.rem              = d_d.rem - shifted[IdxW-1:0];
        d_d.coord[dim_i][pos] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) d_q <= d_d;
  end

  assign vld_o = vld_q;
  assign d_o   = d_q;

endmodule

`default_nettype wire

/* rtl/ttim_accum.sv */
`default_nettype none

module ttim_accum (
  input  wire logic                                              clk_i,
  input  wire logic                                              rst_ni,
  input  wire logic                                              en_i,
  input  wire logic                                              vld_i,
  input  wire ttim_pkg::div_t                                    d_i,
  input  wire logic [ttim_pkg::MaxDims-1:0][ttim_pkg::IdxW-1:0]  sel_i,
  output      logic                                              vld_o,
  output      logic [ttim_pkg::IdxW-1:0]                         src_o,
  output      logic                                              oor_o
);
  import ttim_pkg::*;

  localparam int PairN = (MaxDims + 1) / 2;

  logic [MaxDims-1:0][IdxW-1:0] prod_q;
  logic [PairN-1:0][IdxW-1:0]   pair_q;
  logic [IdxW-1:0]              src_q, src_d;
  logic [2:0]                   vld_q;
  logic [2:0]                   oor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], vld_i};
    end
  end

  // Scale each coordinate by its source stride
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < MaxDims; i++) begin
        prod_q[i] <= IdxW'(d_i.coord[i] * sel_i[i]);
      end
      oor_q <= {oor_q[1:0], d_i.oor};
    end
  end

  // Add in pairs
  for (genvar p = 0; p < PairN; p++) begin : g_pair
    if (2*p + 1 < MaxDims) begin : g_two
      always_ff @(posedge clk_i) begin
        if (en_i) pair_q[p] <= prod_q[2*p] + prod_q[2*p+1];
      end
    end else begin : g_one
      always_ff @(posedge clk_i) begin
        if (en_i) pair_q[p] <= prod_q[2*p];
      end
    end
  end

  // Final sum; drop it for an index out of range
  always_comb begin
    src_d = '0;
    for (int p = 0; p < PairN; p++) begin
      src_d = src_d + pair_q[p];
    end
    if (oor_q[1]) src_d = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) src_q <= src_d;
  end

  assign vld_o = vld_q[2];
  assign src_o = src_q;
  assign oor_o = oor_q[2];

endmodule

`default_nettype wire

/* rtl/ttim_out_fifo.sv */
`default_nettype none

module ttim_out_fifo (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push_i,
  input  wire logic [ttim_pkg::IdxW-1:0]     src_i,
  input  wire logic                          oor_i,
  output      logic                          room_o,
  output      logic                          valid_o,
  input  wire logic                          ready_i,
  output      logic [ttim_pkg::IdxW-1:0]     src_o,
  output      logic                          oor_o
);
  import ttim_pkg::*;

  logic [1:0][IdxW-1:0] src_q;
  logic [1:0]           oor_q;
  logic                 wr_q, rd_q;
  logic [1:0]           cnt_q;
  logic                 pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != '0);
  assign room_o  = (cnt_q != 2'd2);
  assign src_o   = src_q[rd_q];
  assign oor_o   = oor_q[rd_q];

  // Track fill level and pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop)    rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      src_q[wr_q] <= src_i;
      oor_q[wr_q] <= oor_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/tensor_transpose_index_map_unit.sv */
// Channel  | Handshake                    | Payload
// s_axis   | s_axis_tvalid/s_axis_tready  | tdata: dest_index[31:0]
// m_axis   | m_axis_tvalid/m_axis_tready  | tdata: source_index[31:0], tuser: out_of_range
// cfg      | cfg_valid_i/cfg_ready_o      | cfg_addr_i register index, cfg_data_i value
//
// One index per cycle sustained while the output queue has room and no stride sweep
// runs; the path is an input register, 48 divider stages of two quotient bits each,
// multiply, pair add, final add and the output queue. After every register write the
// strides are swept one dimension per cycle; s_axis_tready is low meanwhile.
// Reset restores rank 1, identity order, all sizes 1, with strides ready at once.
// A stalled output fills a two-entry queue; then the whole pipeline holds.
`default_nettype none

module tensor_transpose_index_map_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output      logic                          s_axis_tready,
  input  wire logic [31:0]                   s_axis_tdata,   // dest_index[31:0]
  output      logic                          m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output      logic [31:0]                   m_axis_tdata,   // source_index[31:0]
  output      logic                          m_axis_tuser,   // out_of_range
  input  wire logic                          cfg_valid_i,
  output      logic                          cfg_ready_o,
  input  wire logic [ttim_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  wire logic [ttim_pkg::CfgDataW-1:0] cfg_data_i
);
  import ttim_pkg::*;

  derived_t          derived;
  logic              en;
  logic              in_xfer;
  logic [DivStages:0] vld;
  div_t              pipe [DivStages+1];
  logic              acc_vld;
  logic [IdxW-1:0]   acc_src;
  logic              acc_oor;
  logic              vld0_q;
  div_t              d0_q;

  ttim_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .derived_o   (derived)
  );

  assign s_axis_tready = en && !derived.busy;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // Register the index and flag it against the element count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
    end else if (en) begin
      vld0_q <= in_xfer;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d0_q.rem   <= s_axis_tdata;
      d0_q.coord <= '0;
      d0_q.oor   <= {1'b0, s_axis_tdata} >= derived.count;
    end
  end

  assign vld[0]  = vld0_q;
  assign pipe[0] = d0_q;

  // Divider chain: each dimension takes StepsPerDim stages
  for (genvar s = 0; s < DivStages; s++) begin : g_div
    localparam int Dim  = s / StepsPerDim;
    localparam int Step = s % StepsPerDim;
    ttim_div_stage u_stage (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en),
      .vld_i    (vld[s]),
      .d_i      (pipe[s]),
      .stride_i (derived.dst_stride[Dim]),
      .dim_i    (DimIdxW'(Dim)),
      .step_i   (StepIdxW'(Step)),
      .vld_o    (vld[s+1]),
      .d_o      (pipe[s+1])
    );
  end

  ttim_accum u_accum (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (vld[DivStages]),
    .d_i    (pipe[DivStages]),
    .sel_i  (derived.sel_stride),
    .vld_o  (acc_vld),
    .src_o  (acc_src),
    .oor_o  (acc_oor)
  );

  // Output queue; the pipeline advances while it has room
  ttim_out_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (acc_vld && en),
    .src_i   (acc_src),
    .oor_i   (acc_oor),
    .room_o  (en),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .src_o   (m_axis_tdata),
    .oor_o   (m_axis_tuser)
  );

endmodule

`default_nettype wire

/* rtl/ttim_checker.sv */
`default_nettype none

module ttim_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          s_axis_tready,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [31:0]                   m_axis_tdata,
  input wire logic                          m_axis_tuser,
  input wire logic                          cfg_valid_i,
  input wire logic                          cfg_ready_o
);

  // An out-of-range result carries a zero index
  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("out-of-range result with nonzero index");

  // A register write blocks input while strides are rebuilt
  a_cfg_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |=> !s_axis_tready ##1 !s_axis_tready)
    else $error("input accepted during stride sweep");

  // A result held under backpressure stays offered and stable
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

endmodule

bind tensor_transpose_index_map_unit ttim_checker u_ttim_checker (.*);

`default_nettype wire
